// ===== hdl/set_min_gap_and_range_defines.svh =====
// ----------------------------------------------------------------------------
// set_min_gap_and_range_defines.svh
// Assertion macros shared by the minimum gap and range block.
// ----------------------------------------------------------------------------
`ifndef SET_MIN_GAP_AND_RANGE_DEFINES_SVH
`define SET_MIN_GAP_AND_RANGE_DEFINES_SVH

// Checks that cons holds in the same cycle as ante.
`define SMGR_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante.
`define SMGR_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/smgr_pkg.sv =====
// ----------------------------------------------------------------------------
// smgr_pkg
// Types and constants shared by the minimum gap and range block.
// ----------------------------------------------------------------------------
package smgr_pkg;

  // Widths of the data path.
  localparam int DATA_W = 32;
  localparam int GAP_W  = DATA_W + 1;
  localparam int CAP_W  = 7;

  // Defaults and fixed values.
  localparam int               DEF_MAX_ENTRIES = 64;
  localparam logic [CAP_W-1:0] CAP_RESET       = 7'd64;
  localparam int               MIN_VALUES      = 2;
  localparam logic [GAP_W-1:0] GAP_NONE        = {GAP_W{1'b1}};

  // Operation carried by a token through the cell chain.
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_REJ = 2'd1,
    OP_CLR = 2'd2
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_FEW  = 2'd2,
    ST_CAP0 = 2'd3
  } stat_t;

  // Token payload that moves one cell per cycle.
  typedef struct packed {
    op_t                op;
    logic [DATA_W-1:0]  value;
    logic [GAP_W-1:0]   gap;
  } tok_t;

endpackage

// ===== hdl/set_min_gap_and_range.sv =====
// ----------------------------------------------------------------------------
// set_min_gap_and_range
// Path: the accepting edge loads the first of MAX_ENTRIES cell registers;
// the token then passes the other cells and one result register to the strobe.
// Throughput: one item per cycle; each value walks the cell chain, one cell
// per cycle, so the chain length sets the latency and busy stays low.
// Reset: the set is empty, the capacity is 64 and no result is pending.
// The receiver cannot stall; each result strobe lasts one cycle.
// ----------------------------------------------------------------------------
`include "set_min_gap_and_range_defines.svh"

module set_min_gap_and_range #(
  parameter int MAX_ENTRIES = smgr_pkg::DEF_MAX_ENTRIES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_command,
  input  logic signed [smgr_pkg::DATA_W-1:0] in_value,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [smgr_pkg::DATA_W-1:0]        out_shortest_span,
  output logic [smgr_pkg::DATA_W-1:0]        out_longest_span,
  output logic [smgr_pkg::CAP_W-1:0]         out_held_count,
  input  logic                               cfg_we,
  input  logic [smgr_pkg::CAP_W-1:0]         cfg_wdata
);

  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CW > smgr_pkg::CAP_W) ? CW : smgr_pkg::CAP_W;

  logic [smgr_pkg::CAP_W-1:0] cfg_capacity_r;
  logic [CW-1:0]              count_r;
  logic [CW-1:0]              count_nxt;
  logic                       accept;
  logic                       full;
  logic                       cap_zero;
  smgr_pkg::tok_t             head_tok;
  logic                       tail_vld;
  smgr_pkg::tok_t             tail_tok;
  logic [CW-1:0]              tail_idx;

  // The chain takes a new item in every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_capacity_r <= smgr_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cfg_capacity_r <= cfg_wdata;
    end
  end

  assign cap_zero = (cfg_capacity_r == '0);

  // The set is full at the capacity or at the number of cells.
  assign full = (CMP_W'(count_r) >= CMP_W'(cfg_capacity_r)) ||
                (count_r == CW'(MAX_ENTRIES));

  // Build the token and the fill count for a transfer.
  always_comb begin
    head_tok.value = in_value;
    head_tok.gap   = smgr_pkg::GAP_NONE;
    count_nxt      = count_r;
    if (in_command) begin
      head_tok.op = smgr_pkg::OP_CLR;
      count_nxt   = '0;
    end else if (full) begin
      head_tok.op = smgr_pkg::OP_REJ;
    end else begin
      head_tok.op = smgr_pkg::OP_ADD;
      count_nxt   = count_r + CW'(1);
    end
  end

  // Fill count as seen by items entering the chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // Cell chain.
  smgr_chain #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .CW          (CW)
  ) u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (accept),
    .tok_i (head_tok),
    .idx_i (count_r),
    .vld_o (tail_vld),
    .tok_o (tail_tok),
    .idx_o (tail_idx)
  );

  // Result stage.
  smgr_out #(
    .CW (CW)
  ) u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .vld_i             (tail_vld),
    .tok_i             (tail_tok),
    .idx_i             (tail_idx),
    .cap_zero_i        (cap_zero),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_shortest_span (out_shortest_span),
    .out_longest_span  (out_longest_span),
    .out_held_count    (out_held_count)
  );

  // Checks on the fill count.
  `SMGR_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(MAX_ENTRIES), "fill count above cell count")
  `SMGR_ASSERT_NEXT(a_add_grows, clk, rst_n, accept && !in_command && !full, count_r == $past(count_r) + CW'(1), "add did not grow the set")
  `SMGR_ASSERT_NEXT(a_reject_holds, clk, rst_n, accept && !in_command && full, $stable(count_r), "rejected add changed the set")
  `SMGR_ASSERT_NEXT(a_clear_empties, clk, rst_n, accept && in_command, count_r == '0, "clear left values in the set")

endmodule

// ===== hdl/smgr_cell.sv =====
// ----------------------------------------------------------------------------
// smgr_cell
// One cell of the chain: holds one set entry, folds the distance between a
// passing add's value and its entry into the token when the cell lies below
// the add's target, and stores the value when the token targets this cell.
// ----------------------------------------------------------------------------
module smgr_cell #(
  parameter int CW       = 7,
  parameter int CELL_IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  input  smgr_pkg::tok_t tok_i,
  input  logic [CW-1:0]  idx_i,
  output logic           vld_o,
  output smgr_pkg::tok_t tok_o,
  output logic [CW-1:0]  idx_o
);

  localparam logic [CW-1:0] MY_IDX = CW'(CELL_IDX);

  logic                              vld_r;
  smgr_pkg::tok_t                    tok_r;
  smgr_pkg::tok_t                    tok_nxt;
  logic [CW-1:0]                     idx_r;
  logic [smgr_pkg::DATA_W-1:0]       held_r;
  logic                              hit_cmp;
  logic                              hit_store;
  logic [smgr_pkg::GAP_W-1:0]        a_ext;
  logic [smgr_pkg::GAP_W-1:0]        b_ext;
  logic [smgr_pkg::GAP_W-1:0]        d_ab;
  logic [smgr_pkg::GAP_W-1:0]        d_ba;
  logic [smgr_pkg::GAP_W-1:0]        abs_diff;

  // An add compares against entries below its target and stores at its target.
  assign hit_cmp   = vld_i && (tok_i.op == smgr_pkg::OP_ADD) && (idx_i > MY_IDX);
  assign hit_store = vld_i && (tok_i.op == smgr_pkg::OP_ADD) && (idx_i == MY_IDX);

  // Absolute difference, formed 33 bits wide so it cannot overflow.
  always_comb begin
    a_ext    = {tok_i.value[smgr_pkg::DATA_W-1], tok_i.value};
    b_ext    = {held_r[smgr_pkg::DATA_W-1], held_r};
    d_ab     = a_ext - b_ext;
    d_ba     = b_ext - a_ext;
    abs_diff = d_ab[smgr_pkg::GAP_W-1] ? d_ba : d_ab;
  end

  // Keep the smaller gap in the token.
  always_comb begin
    tok_nxt = tok_i;
    if (hit_cmp && (abs_diff < tok_i.gap)) begin
      tok_nxt.gap = abs_diff;
    end
  end

  // Token valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  // Token payload and the held entry.
  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    idx_r <= idx_i;
    if (hit_store) begin
      held_r <= tok_i.value;
    end
  end

  assign vld_o = vld_r;
  assign tok_o = tok_r;
  assign idx_o = idx_r;

endmodule

// ===== hdl/smgr_chain.sv =====
// ----------------------------------------------------------------------------
// smgr_chain
// Row of cells, one per set entry; a token moves one cell each cycle.
// ----------------------------------------------------------------------------
module smgr_chain #(
  parameter int MAX_ENTRIES = smgr_pkg::DEF_MAX_ENTRIES,
  parameter int CW          = $clog2(MAX_ENTRIES + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  input  smgr_pkg::tok_t tok_i,
  input  logic [CW-1:0]  idx_i,
  output logic           vld_o,
  output smgr_pkg::tok_t tok_o,
  output logic [CW-1:0]  idx_o
);

  logic           vld_w [0:MAX_ENTRIES];
  smgr_pkg::tok_t tok_w [0:MAX_ENTRIES];
  logic [CW-1:0]  idx_w [0:MAX_ENTRIES];

  assign vld_w[0] = vld_i;
  assign tok_w[0] = tok_i;
  assign idx_w[0] = idx_i;

  // Each cell hands its token to the next one.
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    smgr_cell #(
      .CW       (CW),
      .CELL_IDX (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vld_w[g]),
      .tok_i (tok_w[g]),
      .idx_i (idx_w[g]),
      .vld_o (vld_w[g+1]),
      .tok_o (tok_w[g+1]),
      .idx_o (idx_w[g+1])
    );
  end

  assign vld_o = vld_w[MAX_ENTRIES];
  assign tok_o = tok_w[MAX_ENTRIES];
  assign idx_o = idx_w[MAX_ENTRIES];

endmodule

// ===== hdl/smgr_out.sv =====
// ----------------------------------------------------------------------------
// smgr_out
// Result stage: keeps the best gap, minimum and maximum in token order and
// registers the result.
// ----------------------------------------------------------------------------
module smgr_out #(
  parameter int CW = 7
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               vld_i,
  input  smgr_pkg::tok_t                     tok_i,
  input  logic [CW-1:0]                      idx_i,
  input  logic                               cap_zero_i,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [smgr_pkg::DATA_W-1:0]        out_shortest_span,
  output logic [smgr_pkg::DATA_W-1:0]        out_longest_span,
  output logic [smgr_pkg::CAP_W-1:0]         out_held_count
);

  logic [smgr_pkg::GAP_W-1:0]         best_r;
  logic [smgr_pkg::GAP_W-1:0]         best_nxt;
  logic signed [smgr_pkg::DATA_W-1:0] min_r;
  logic signed [smgr_pkg::DATA_W-1:0] min_nxt;
  logic signed [smgr_pkg::DATA_W-1:0] max_r;
  logic signed [smgr_pkg::DATA_W-1:0] max_nxt;
  logic signed [smgr_pkg::DATA_W-1:0] val;
  logic [CW-1:0]                      cnt_new;
  smgr_pkg::stat_t                    stat;
  logic [smgr_pkg::DATA_W-1:0]        short_nxt;
  logic [smgr_pkg::DATA_W-1:0]        long_nxt;

  logic                               out_valid_r;
  smgr_pkg::stat_t                    out_status_r;
  logic [smgr_pkg::DATA_W-1:0]        out_short_r;
  logic [smgr_pkg::DATA_W-1:0]        out_long_r;
  logic [smgr_pkg::CAP_W-1:0]         out_count_r;

  assign val = tok_i.value;

  // Update of the running statistics for the token leaving the chain.
  always_comb begin
    best_nxt = best_r;
    min_nxt  = min_r;
    max_nxt  = max_r;
    cnt_new  = idx_i;
    stat     = smgr_pkg::ST_FULL;
    case (tok_i.op)
      smgr_pkg::OP_CLR: begin
        best_nxt = smgr_pkg::GAP_NONE;
        min_nxt  = '0;
        max_nxt  = '0;
        cnt_new  = '0;
        stat     = cap_zero_i ? smgr_pkg::ST_CAP0 : smgr_pkg::ST_FEW;
      end
      smgr_pkg::OP_REJ: begin
        stat = smgr_pkg::ST_FULL;
      end
      smgr_pkg::OP_ADD: begin
        cnt_new = idx_i + CW'(1);
        if (tok_i.gap < best_r) begin
          best_nxt = tok_i.gap;
        end
        if (idx_i == '0) begin
          min_nxt = val;
          max_nxt = val;
        end else begin
          if (val < min_r) begin
            min_nxt = val;
          end
          if (val > max_r) begin
            max_nxt = val;
          end
        end
        if (cap_zero_i) begin
          stat = smgr_pkg::ST_CAP0;
        end else if (cnt_new >= CW'(smgr_pkg::MIN_VALUES)) begin
          stat = smgr_pkg::ST_OK;
        end else begin
          stat = smgr_pkg::ST_FEW;
        end
      end
      default: begin
        stat = smgr_pkg::ST_FULL;
      end
    endcase
  end

  // Spans are reported only with an ok status.
  always_comb begin
    short_nxt = '0;
    long_nxt  = '0;
    if (stat == smgr_pkg::ST_OK) begin
      short_nxt = best_nxt[smgr_pkg::DATA_W-1:0];
      long_nxt  = max_nxt - min_nxt;
    end
  end

  // Running statistics.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= smgr_pkg::GAP_NONE;
      min_r  <= '0;
      max_r  <= '0;
    end else if (vld_i) begin
      best_r <= best_nxt;
      min_r  <= min_nxt;
      max_r  <= max_nxt;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (vld_i) begin
      out_status_r <= stat;
      out_short_r  <= short_nxt;
      out_long_r   <= long_nxt;
      out_count_r  <= smgr_pkg::CAP_W'(cnt_new);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_shortest_span = out_short_r;
  assign out_longest_span  = out_long_r;
  assign out_held_count    = out_count_r;

endmodule
